/* hdl/fmd_pkg.sv */
// Shared types and constants for the footprint mask dilation block.
`default_nettype none
package fmd_pkg;

    localparam int MAP_W    = 256;
    localparam int MAP_H    = 256;
    localparam int MAX_HALF = 15;

    localparam int COL_W      = $clog2(MAP_W);
    localparam int ROW_W      = $clog2(MAP_H);
    localparam int HALF_W     = 4;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H  = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             command;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             struct_bit;
        logic             water_bit;
    } req_t;

    typedef struct packed {
        logic struct_hit;
        logic water_hit;
        logic status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WR_READ,
        ST_WR_MODIFY,
        ST_ROW_READ,
        ST_ROW_ACC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic setup;
        logic rd_item_row;
        logic rd_scan_row;
        logic wr_row;
        logic accumulate;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_of_map;
        logic is_query;
        logic last_row;
        logic out_slot_free;
    } dp_status_t;

endpackage
`default_nettype wire

/* hdl/fmd_if.sv */
// Request and response channel interfaces.
`default_nettype none
interface fmd_req_if;
    import fmd_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fmd_rsp_if;
    import fmd_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/footprint_mask_dilation.sv */
// Top level of the footprint mask dilation block.
// Two 256 x 256 one-bit masks are kept as rows of 256 bits in a single-port
// row store with registered read; every row has a valid bit cleared at reset,
// so the masks read as zero after reset with no clearing pass. A write request
// goes through check, row read, row write back and result. A query goes through
// check, then a row read and an accumulate step for each of n sampled rows (at
// most 16), then result: each sampled row is read and then its sampled columns
// are ORed into the hits. A request outside the configured map goes from check
// straight to result. One request is processed at a time; the next one is
// accepted while the previous result still waits in the output register.
`default_nettype none
module footprint_mask_dilation
    import fmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    fmd_req_if.sink                    req,
    fmd_rsp_if.source                  rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_ready;

    assign req.ready = req_ready;

    fmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fmd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_payload (req.payload),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_payload (rsp.payload),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
`default_nettype wire

/* hdl/fmd_ctrl.sv */
// Sequencer for writes and footprint scans.
`default_nettype none
module fmd_ctrl
    import fmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.out_of_map)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.is_query)
                begin
                    state_next = ST_ROW_READ;
                end
                else
                begin
                    state_next = ST_WR_READ;
                end
            end
            ST_WR_READ:   state_next = ST_WR_MODIFY;
            ST_WR_MODIFY: state_next = ST_FINISH;
            ST_ROW_READ:  state_next = ST_ROW_ACC;
            ST_ROW_ACC:
            begin
                state_next = status.last_row ? ST_FINISH : ST_ROW_READ;
            end
            ST_FINISH:
            begin
                if (status.out_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
            end
            ST_CHECK:     cmd.setup       = 1'b1;
            ST_WR_READ:   cmd.rd_item_row = 1'b1;
            ST_WR_MODIFY: cmd.wr_row      = 1'b1;
            ST_ROW_READ:  cmd.rd_scan_row = 1'b1;
            ST_ROW_ACC:   cmd.accumulate  = 1'b1;
            ST_FINISH:    cmd.emit        = status.out_slot_free;
            default:      cmd             = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/fmd_dp.sv */
// Mask row store, footprint bounds, scan accumulators and result register.
`default_nettype none
module fmd_dp
    import fmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire req_t                  req_payload,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output rsp_t                       rsp_payload,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status
);

    logic [HALF_W-1:0] half_x_reg;
    logic [HALF_W-1:0] half_z_reg;
    logic [SIZE_W-1:0] map_w_reg;
    logic [SIZE_W-1:0] map_h_reg;

    req_t              item_reg;
    logic [MAP_W-1:0]  colmask_reg;
    logic [MAP_W-1:0]  colmask_next;
    logic [ROW_W-1:0]  z_reg;
    logic [ROW_W-1:0]  z1_reg;
    logic              acc_s_reg;
    logic              acc_w_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [MAP_W-1:0]  struct_mem [MAP_H];
    logic [MAP_W-1:0]  water_mem [MAP_H];
    logic [MAP_H-1:0]  row_valid_reg;
    logic [MAP_W-1:0]  struct_rd_reg;
    logic [MAP_W-1:0]  water_rd_reg;
    logic              rd_valid_reg;

    logic [HALF_W-1:0] hx;
    logic [HALF_W-1:0] hz;
    logic [SIZE_W-1:0] w_sat;
    logic [SIZE_W-1:0] h_sat;
    logic              out_of_map;
    logic [COL_W-1:0]  x0;
    logic [COL_W-1:0]  x1;
    logic [SIZE_W-1:0] x_sum;
    logic [SIZE_W-1:0] w_last;
    logic [ROW_W-1:0]  z0;
    logic [ROW_W-1:0]  z1;
    logic [SIZE_W-1:0] z_sum;
    logic [SIZE_W-1:0] h_last;
    logic [SIZE_W-1:0] z_step;
    logic [ROW_W-1:0]  rd_addr;
    logic              rd_en;
    logic [MAP_W-1:0]  struct_wr;
    logic [MAP_W-1:0]  water_wr;
    logic              slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= HALF_W'(1);
            half_z_reg <= HALF_W'(1);
            map_w_reg  <= SIZE_W'(MAP_W);
            map_h_reg  <= SIZE_W'(MAP_H);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_X: half_x_reg <= cfg_data[HALF_W-1:0];
                CFG_HALF_Z: half_z_reg <= cfg_data[HALF_W-1:0];
                CFG_MAP_W:  map_w_reg  <= cfg_data[SIZE_W-1:0];
                CFG_MAP_H:  map_h_reg  <= cfg_data[SIZE_W-1:0];
                default:    half_x_reg <= half_x_reg;
            endcase
        end
    end

    always_comb
    begin
        hx     = (half_x_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_x_reg;
        hz     = (half_z_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_z_reg;
        w_sat  = (map_w_reg > SIZE_W'(MAP_W)) ? SIZE_W'(MAP_W) : map_w_reg;
        h_sat  = (map_h_reg > SIZE_W'(MAP_H)) ? SIZE_W'(MAP_H) : map_h_reg;

        out_of_map = ({1'b0, item_reg.col} >= w_sat) || ({1'b0, item_reg.row} >= h_sat);

        x0     = (item_reg.col >= COL_W'(hx)) ? item_reg.col - COL_W'(hx) : '0;
        x_sum  = {1'b0, item_reg.col} + SIZE_W'(hx);
        w_last = w_sat - SIZE_W'(1);
        x1     = (x_sum > w_last) ? w_last[COL_W-1:0] : x_sum[COL_W-1:0];

        z0     = (item_reg.row >= ROW_W'(hz)) ? item_reg.row - ROW_W'(hz) : '0;
        z_sum  = {1'b0, item_reg.row} + SIZE_W'(hz);
        h_last = h_sat - SIZE_W'(1);
        z1     = (z_sum > h_last) ? h_last[ROW_W-1:0] : z_sum[ROW_W-1:0];

        for (int i = 0; i < MAP_W; i++)
        begin
            colmask_next[i] = (COL_W'(i) >= x0) && (COL_W'(i) <= x1)
                              && (COL_W'(i) & COL_W'(1)) == (x0 & COL_W'(1));
        end

        z_step = {1'b0, z_reg} + SIZE_W'(2);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req_payload;
        end
        if (cmd.setup)
        begin
            colmask_reg <= colmask_next;
            z_reg       <= z0;
            z1_reg      <= z1;
        end
        else if (cmd.accumulate)
        begin
            z_reg <= z_step[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_s_reg <= 1'b0;
            acc_w_reg <= 1'b0;
        end
        else if (cmd.setup)
        begin
            acc_s_reg <= 1'b0;
            acc_w_reg <= 1'b0;
        end
        else if (cmd.accumulate)
        begin
            acc_s_reg <= acc_s_reg | (rd_valid_reg & (|(struct_rd_reg & colmask_reg)));
            acc_w_reg <= acc_w_reg | (rd_valid_reg & (|(water_rd_reg & colmask_reg)));
        end
    end

    assign rd_en   = cmd.rd_item_row | cmd.rd_scan_row;
    assign rd_addr = cmd.rd_item_row ? item_reg.row : z_reg;

    always_comb
    begin
        struct_wr                = rd_valid_reg ? struct_rd_reg : '0;
        water_wr                 = rd_valid_reg ? water_rd_reg : '0;
        struct_wr[item_reg.col]  = item_reg.struct_bit;
        water_wr[item_reg.col]   = item_reg.water_bit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_row)
        begin
            struct_mem[item_reg.row] <= struct_wr;
            water_mem[item_reg.row]  <= water_wr;
        end
        if (rd_en)
        begin
            struct_rd_reg <= struct_mem[rd_addr];
            water_rd_reg  <= water_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_row)
            begin
                row_valid_reg[item_reg.row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign slot_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.struct_hit <= acc_s_reg;
            out_reg.water_hit  <= acc_w_reg;
            out_reg.status     <= out_of_map;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_payload = out_reg;

    assign status.out_of_map    = out_of_map;
    assign status.is_query      = (item_reg.command == CMD_QUERY);
    assign status.last_row      = (z_step > {1'b0, z1_reg});
    assign status.out_slot_free = slot_free;

endmodule
`default_nettype wire

/* tb/tb_footprint_mask_dilation.sv */
// Self-checking testbench for footprint_mask_dilation with a built-in mask dilation predictor.
module tb_footprint_mask_dilation;
    import fmd_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fmd_req_if req_ch ();
    fmd_rsp_if rsp_ch ();

    footprint_mask_dilation DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    bit              struct_map [MAP_H][MAP_W];
    bit              water_map  [MAP_H][MAP_W];
    logic [HALF_W-1:0] cfg_half_x = 4'd1;
    logic [HALF_W-1:0] cfg_half_z = 4'd1;
    logic [SIZE_W-1:0] cfg_map_w  = 9'd256;
    logic [SIZE_W-1:0] cfg_map_h  = 9'd256;

    rsp_t pending_hits [$];
    int   err_count = 0;
    bit   idle_on = 1'b1;
    int   hold_req = 0;
    int   rand_density = 4;
    int   box_col = 0;
    int   box_row = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int map_cols();
        return (cfg_map_w > MAP_W) ? MAP_W : int'(cfg_map_w);
    endfunction

    function automatic int map_rows();
        return (cfg_map_h > MAP_H) ? MAP_H : int'(cfg_map_h);
    endfunction

    function automatic rsp_t dilated_hits(req_t r);
        rsp_t res;
        int w, h, hx, hz, c, rw, x0, x1, z0, z1;
        res = '0;
        w  = map_cols();
        h  = map_rows();
        hx = (cfg_half_x > MAX_HALF) ? MAX_HALF : int'(cfg_half_x);
        hz = (cfg_half_z > MAX_HALF) ? MAX_HALF : int'(cfg_half_z);
        c  = r.col;
        rw = r.row;
        if (c >= w || rw >= h)
        begin
            res.status = 1'b1;
        end
        else if (r.command == CMD_WRITE)
        begin
            struct_map[rw][c] = r.struct_bit;
            water_map[rw][c]  = r.water_bit;
        end
        else
        begin
            x0 = (c >= hx) ? c - hx : 0;
            x1 = (c + hx > w - 1) ? w - 1 : c + hx;
            z0 = (rw >= hz) ? rw - hz : 0;
            z1 = (rw + hz > h - 1) ? h - 1 : rw + hz;
            for (int z = z0; z <= z1; z += 2)
            begin
                for (int x = x0; x <= x1; x += 2)
                begin
                    res.struct_hit |= struct_map[z][x];
                    res.water_hit  |= water_map[z][x];
                end
            end
        end
        return res;
    endfunction

    function automatic req_t mk_req(logic cmd, int c, int r, logic s, logic w);
        req_t q;
        q.command    = cmd;
        q.col        = c[COL_W-1:0];
        q.row        = r[ROW_W-1:0];
        q.struct_bit = s;
        q.water_bit  = w;
        return q;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int w, h, pick;
        w = map_cols();
        h = map_rows();
        r.command    = 1'($urandom_range(0, 1));
        r.struct_bit = ($urandom_range(0, rand_density) == 0);
        r.water_bit  = ($urandom_range(0, rand_density) == 0);
        pick = $urandom_range(0, 9);
        if (w == 0 || h == 0 || pick == 9)
        begin
            r.col = COL_W'($urandom_range(0, 255));
            r.row = ROW_W'($urandom_range(0, 255));
        end
        else if (pick >= 7)
        begin
            r.col = COL_W'($urandom_range(0, w - 1));
            r.row = ROW_W'($urandom_range(0, h - 1));
        end
        else
        begin
            r.col = COL_W'((box_col + $urandom_range(0, 2 * cfg_half_x + 3)) % w);
            r.row = ROW_W'((box_row + $urandom_range(0, 2 * cfg_half_z + 3)) % h);
        end
        return r;
    endfunction

    task automatic move_window();
        box_col = (map_cols() > 0) ? $urandom_range(0, map_cols() - 1) : 0;
        box_row = (map_rows() > 0) ? $urandom_range(0, map_rows() - 1) : 0;
    endtask

    task automatic issue_request(req_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_hits.push_back(dilated_hits(r));
    endtask

    task automatic wait_all_responses();
        req_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_HALF_X: cfg_half_x = data[HALF_W-1:0];
            CFG_HALF_Z: cfg_half_z = data[HALF_W-1:0];
            CFG_MAP_W:  cfg_map_w  = data;
            CFG_MAP_H:  cfg_map_h  = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(int hx, int hz, int w, int h);
        write_reg(CFG_HALF_X, hx[CFG_DATA_W-1:0]);
        write_reg(CFG_HALF_Z, hz[CFG_DATA_W-1:0]);
        write_reg(CFG_MAP_W, w[CFG_DATA_W-1:0]);
        write_reg(CFG_MAP_H, h[CFG_DATA_W-1:0]);
    endtask

    function automatic void compare_bit(string field, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, actual %0b", field, want, got);
            err_count++;
        end
    endfunction

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (pending_hits.size() == 0)
        begin
            $error("response with no request outstanding: %p", got);
            err_count++;
            return;
        end
        want = pending_hits.pop_front();
        compare_bit("struct_hit", want.struct_hit, got.struct_hit);
        compare_bit("water_hit", want.water_hit, got.water_hit);
        compare_bit("status", want.status, got.status);
    endtask

    initial
    begin
        int stall;
        int hold_cnt;
        stall = 0;
        hold_cnt = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                check_rsp(rsp_ch.payload);
                stall = idle_on ? $urandom_range(0, 18) : 0;
            end
            if (hold_req > 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_after_reset();
        issue_request(mk_req(CMD_QUERY, 0, 0, 1'b1, 1'b1));
        issue_request(mk_req(CMD_QUERY, 255, 255, 1'b0, 1'b1));
        issue_request(mk_req(CMD_QUERY, 128, 77, 1'b1, 1'b0));
        wait_all_responses();
    endtask

    task automatic test_corner_cells();
        issue_request(mk_req(CMD_WRITE, 0, 0, 1'b1, 1'b0));
        issue_request(mk_req(CMD_WRITE, 255, 255, 1'b0, 1'b1));
        issue_request(mk_req(CMD_WRITE, 255, 0, 1'b1, 1'b1));
        issue_request(mk_req(CMD_WRITE, 0, 255, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 1, 1, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 2, 2, 1'b1, 1'b1));
        issue_request(mk_req(CMD_QUERY, 254, 254, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 255, 255, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 254, 1, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 0, 0, 1'b0, 1'b0));
        issue_request(mk_req(CMD_WRITE, 0, 0, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 1, 1, 1'b0, 1'b0));
        wait_all_responses();
        apply_setting(1, 1, 200, 100);
        issue_request(mk_req(CMD_WRITE, 220, 50, 1'b1, 1'b1));
        issue_request(mk_req(CMD_QUERY, 50, 150, 1'b0, 1'b0));
        issue_request(mk_req(CMD_WRITE, 199, 99, 1'b1, 1'b0));
        issue_request(mk_req(CMD_QUERY, 199, 99, 1'b0, 1'b0));
        issue_request(mk_req(CMD_WRITE, 210, 10, 1'b1, 1'b1));
        wait_all_responses();
        write_reg(CFG_HALF_X, 9'h1F0);
        write_reg(CFG_HALF_Z, 9'h1F0);
        write_reg(CFG_MAP_W, 9'd256);
        write_reg(CFG_MAP_H, 9'd256);
        issue_request(mk_req(CMD_QUERY, 210, 10, 1'b0, 1'b0));
        issue_request(mk_req(CMD_QUERY, 255, 0, 1'b0, 1'b0));
        wait_all_responses();
    endtask

    task automatic test_config_sweep();
        int settings [9][4];
        int n;
        settings = '{
            '{1, 1, 256, 256}, '{0, 0, 256, 256}, '{15, 15, 256, 256},
            '{15, 0, 1, 1}, '{0, 15, 256, 1}, '{3, 2, 37, 200},
            '{7, 5, 511, 300}, '{2, 2, 0, 5}, '{4, 9, 129, 64}
        };
        foreach (settings[i])
        begin
            apply_setting(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
            rand_density = $urandom_range(2, 12);
            n = (map_cols() == 0 || map_rows() == 0) ? 30 : 120;
            for (int k = 0; k < n; k++)
            begin
                if (k % 32 == 0)
                    move_window();
                issue_request(rand_req());
            end
            wait_all_responses();
        end
    endtask

    task automatic test_backpressure();
        apply_setting(6, 3, 256, 256);
        move_window();
        idle_on = 1'b0;
        hold_req = 300;
        for (int k = 0; k < 30; k++)
            issue_request(rand_req());
        wait_all_responses();
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        apply_setting(2, 4, 97, 180);
        idle_on = 1'b0;
        for (int k = 0; k < 60; k++)
        begin
            if (k % 20 == 0)
                move_window();
            issue_request(rand_req());
        end
        wait_all_responses();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_HALF_X;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_corner_cells();
        test_config_sweep();
        test_backpressure();
        test_back_to_back();
        wait_all_responses();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("[footprint_mask_dilation] OK");
        else
            $display("[footprint_mask_dilation] ERROR");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("[footprint_mask_dilation] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/fmd_pkg.sv
hdl/fmd_if.sv
hdl/fmd_ctrl.sv
hdl/fmd_dp.sv
hdl/footprint_mask_dilation.sv
tb/tb_footprint_mask_dilation.sv
